// File: rtl/tbpc_pkg.sv
// Shared types, constants and the group firing order for the burst-fire triac controller.
// No dependencies.
package tbpc_pkg;

  localparam int unsigned GROUP_COUNT = 10;
  localparam logic [3:0]  GROUP_LAST  = 4'(GROUP_COUNT - 1);
  localparam logic [7:0]  PERCENT_MAX = 8'd100;
  localparam logic [7:0]  HALF_WAVE_TICKS_RESET = 8'd100;

  // Multiply-and-shift reciprocal for division by ten, exact for values up to 1028.
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_PERCENT = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] percent;
  } tbpc_in_t;

  typedef struct packed {
    logic       drive_on;
    logic [3:0] group_index;
  } tbpc_out_t;

  typedef struct packed {
    logic     vld;
    tbpc_in_t item;
  } tbpc_stage_t;

  function automatic logic [3:0] rank_of(input logic [3:0] g);
    logic [3:0] r;
    case (g)
      4'd0:    r = 4'd0;
      4'd5:    r = 4'd1;
      4'd2:    r = 4'd2;
      4'd7:    r = 4'd3;
      4'd4:    r = 4'd4;
      4'd9:    r = 4'd5;
      4'd1:    r = 4'd6;
      4'd6:    r = 4'd7;
      4'd3:    r = 4'd8;
      4'd8:    r = 4'd9;
      default: r = 4'(GROUP_COUNT);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tbpc_in_stage.sv
// Input register of the burst-fire controller: captures one transaction and holds it
// until the core takes it. Depends on tbpc_pkg.
module tbpc_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tbpc_pkg::tbpc_in_t    in_data,
  input  logic                  core_ready,
  output tbpc_pkg::tbpc_stage_t stage
);
  import tbpc_pkg::*;

  logic     vld_r, vld_nxt;
  tbpc_in_t item_r;
  logic     accept;

  assign in_stall = vld_r && !core_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (core_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (accept) begin
      item_r <= in_data;
    end
  end

  assign stage.vld  = vld_r;
  assign stage.item = item_r;

endmodule

// File: rtl/tbpc_core.sv
// Controller state, configuration register and result register of the burst-fire
// controller. Depends on tbpc_pkg.
module tbpc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbpc_pkg::tbpc_stage_t stage,
  output logic                  core_ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tbpc_pkg::tbpc_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import tbpc_pkg::*;

  logic [7:0]  hwt_r;
  logic [11:0] tick_r, tick_nxt;
  logic [3:0]  group_r, group_nxt;
  logic [3:0]  halves_r, halves_nxt;
  logic [3:0]  extra_r, extra_nxt;
  logic        drive_r, drive_nxt;
  logic        out_vld_r, out_vld_nxt;
  tbpc_out_t   out_r;

  logic        advance;
  logic [11:0] tick_inc;
  logic [11:0] bound;
  logic [3:0]  halves_g;
  logic [11:0] on_time;
  logic [6:0]  pct_clamp;
  logic [14:0] pct_prod;
  logic [3:0]  pct_q;
  logic [6:0]  pct_q10;

  assign cfg_ready  = 1'b1;
  assign core_ready = !out_vld_r || !out_stall;
  assign advance    = stage.vld && core_ready;

  assign tick_inc = tick_r + 12'd1;
  assign bound    = {1'b0, hwt_r, 3'b000} + {3'b000, hwt_r, 1'b0};
  assign halves_g = halves_r + {3'b000, (rank_of(group_r) < extra_r)};
  assign on_time  = halves_g * hwt_r;

  assign pct_clamp = (stage.item.percent > PERCENT_MAX) ? PERCENT_MAX[6:0]
                                                       : stage.item.percent[6:0];
  assign pct_prod  = pct_clamp * DIV10_MUL;
  assign pct_q     = pct_prod[DIV10_SHIFT +: 4];
  assign pct_q10   = {pct_q, 3'b000} + {2'b00, pct_q, 1'b0};

  always_comb begin
    tick_nxt    = tick_r;
    group_nxt   = group_r;
    halves_nxt  = halves_r;
    extra_nxt   = extra_r;
    drive_nxt   = drive_r;
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
      if (stage.item.req_type == REQ_PERCENT) begin
        halves_nxt = pct_q;
        extra_nxt  = 4'(pct_clamp - pct_q10);
      end else if (tick_inc <= bound) begin
        tick_nxt  = tick_inc;
        drive_nxt = (tick_inc <= on_time);
      end else begin
        tick_nxt  = '0;
        group_nxt = (group_r == GROUP_LAST) ? 4'd0 : group_r + 4'd1;
      end
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwt_r     <= HALF_WAVE_TICKS_RESET;
      tick_r    <= '0;
      group_r   <= '0;
      halves_r  <= '0;
      extra_r   <= '0;
      drive_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hwt_r <= cfg_data;
      end
      tick_r    <= tick_nxt;
      group_r   <= group_nxt;
      halves_r  <= halves_nxt;
      extra_r   <= extra_nxt;
      drive_r   <= drive_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (advance) begin
      out_r.drive_on    <= drive_nxt;
      out_r.group_index <= group_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/triac_burst_power_control.sv
// Top level of the half-wave burst-fire triac power controller.
// Instantiates tbpc_in_stage and tbpc_core; depends on tbpc_pkg.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall   tbpc_in_t (req_type, percent)
//   out_     output     out_valid/out_stall tbpc_out_t (drive_on, group_index)
//   cfg_     input      cfg_valid/cfg_ready cfg_data = half_wave_ticks
//
// Every transaction yields one result. Acceptance writes the input register; once the result
// register is free (out_valid low or out_stall low), the controller update runs and writes
// the result register, which raises out_valid. The result is taken while out_stall is low.
// A new transaction is accepted every cycle while the result side keeps up.
// Synchronous active-low reset clears the counter, group, percent, drive level and
// sets half_wave_ticks to 100. A stalled result holds and backs up into in_stall.
module triac_burst_power_control (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tbpc_pkg::tbpc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tbpc_pkg::tbpc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tbpc_pkg::*;

  tbpc_stage_t stage;
  logic        core_ready;

  tbpc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .core_ready (core_ready),
    .stage      (stage)
  );

  tbpc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .core_ready (core_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

endmodule

// File: rtl/tbpc_checker.sv
// Port-level checks for the burst-fire triac controller, bound to the top level.
// Depends on tbpc_pkg.
module tbpc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tbpc_pkg::tbpc_out_t out_data
);
  import tbpc_pkg::*;

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.group_index <= GROUP_LAST)
    else $error("Group index out of range.");

  a_group_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) ##1 out_valid |->
      (out_data.group_index == $past(out_data.group_index)) ||
      (out_data.group_index == $past(out_data.group_index) + 4'd1) ||
      ($past(out_data.group_index) == GROUP_LAST && out_data.group_index == 4'd0))
    else $error("Group index skipped between consecutive results.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the result side is free.");

endmodule

bind triac_burst_power_control tbpc_checker u_tbpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb_top.sv
// Self-checking testbench for triac_burst_power_control: random and directed tick and
// set-percent transactions, predicted gate level and group index, across several settings.
// Depends on tbpc_pkg and the controller RTL.
module tb_top;
  import tbpc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 40;
  // Group firing order, entry i in bits [4*i +: 4].
  localparam logic [39:0] FIRE_ORDER = {4'd8, 4'd3, 4'd6, 4'd1, 4'd9, 4'd4, 4'd7, 4'd2,
                                        4'd5, 4'd0};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tbpc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tbpc_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  triac_burst_power_control uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tbpc_in_t    burst_requests[$];
  tbpc_out_t   gate_results_due[$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_accepted = 1'b0;

  logic [7:0]  half_wave = HALF_WAVE_TICKS_RESET;
  logic [11:0] tick_cnt = '0;
  logic [3:0]  group = '0;
  logic [6:0]  power_pct = '0;
  logic        gate_on = 1'b0;

  function automatic tbpc_out_t next_gate_state(input tbpc_in_t req);
    tbpc_out_t   res;
    int unsigned bound;
    int unsigned on_ticks;
    int unsigned fire_rank;
    if (req.req_type == REQ_PERCENT) begin
      power_pct = (req.percent > PERCENT_MAX) ? PERCENT_MAX[6:0] : req.percent[6:0];
    end else begin
      bound = GROUP_COUNT * half_wave;
      tick_cnt = tick_cnt + 12'd1;
      if (tick_cnt <= bound) begin
        fire_rank = GROUP_COUNT;
        for (int i = 0; i < GROUP_COUNT; i++) begin
          if (FIRE_ORDER[4*i +: 4] == group) begin
            fire_rank = i;
          end
        end
        on_ticks = (power_pct / GROUP_COUNT + ((fire_rank < power_pct % GROUP_COUNT) ? 1 : 0))
                   * half_wave;
        gate_on = (tick_cnt <= on_ticks);
      end else begin
        tick_cnt = '0;
        group = (group == GROUP_LAST) ? 4'd0 : group + 4'd1;
      end
    end
    res.drive_on = gate_on;
    res.group_index = group;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < REPORT_LIMIT) begin
      $display("Mismatch at %0t: %s, got %0d, wanted %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic queue_request(input logic kind, input logic [7:0] pct);
    tbpc_in_t req;
    req.req_type = kind;
    req.percent = pct;
    burst_requests.push_back(req);
    requests_queued++;
  endtask

  // Mostly ticks, with occasional percent changes and some out-of-range percents.
  task automatic queue_random(input int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 12) begin
        queue_request(REQ_PERCENT, 8'($urandom_range(100)));
      end else if (r < 15) begin
        queue_request(REQ_PERCENT, 8'($urandom_range(255, 101)));
      end else begin
        queue_request(REQ_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (requests_taken != requests_queued || gate_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] ticks, input int unsigned send_idle,
                           input int unsigned recv_stall, input int unsigned count);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    queue_random(count);
    settle();
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted) begin
        if (burst_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= burst_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic      busy;
    tbpc_out_t due;
    busy = 1'b0;
    in_accepted = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        half_wave = cfg_data;
        busy = 1'b1;
      end
      if (in_accepted) begin
        gate_results_due.push_back(next_gate_state(in_data));
        requests_taken++;
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (gate_results_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(out_data), 0);
        end else begin
          due = gate_results_due.pop_front();
          if (out_data.drive_on !== due.drive_on) begin
            report_mismatch("drive_on", int'(out_data.drive_on), int'(due.drive_on));
          end
          if (out_data.group_index !== due.group_index) begin
            report_mismatch("group_index", int'(out_data.group_index),
                            int'(due.group_index));
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Clamping, the remainder classes 0, 1, 5 and 9 and the percent extremes at the reset setting.
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_TICK, 8'd255);
    queue_request(REQ_PERCENT, 8'd255);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd101);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd100);
    queue_request(REQ_PERCENT, 8'd0);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd5);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd9);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd10);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd50);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd99);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd128);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd1);
    queue_request(REQ_TICK, 8'd0);
    queue_request(REQ_PERCENT, 8'd0);
    queue_request(REQ_TICK, 8'd0);
    queue_random(60);
    settle();

    // The counter now sits well above the bound of the next setting.
    run_phase(8'd2, 83, 0, 250);
    run_phase(8'd1, 0, 83, 250);
    run_phase(8'd0, 11, 11, 40);
    run_phase(8'd255, 0, 0, 80);
    run_phase(8'($urandom_range(6, 1)), 11, 11, 125);
    queue_random(125);
    settle();
    run_phase(8'd3, 0, 0, 100);

    repeat (8) @(negedge clk);
    if (mismatches == 0 && gate_results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tbpc_pkg.sv
rtl/tbpc_in_stage.sv
rtl/tbpc_core.sv
rtl/triac_burst_power_control.sv
rtl/tbpc_checker.sv
tb/tb_top.sv
